FILE: sv/rbs_pkg.sv
// ============================================================================
// rbs_pkg: shared types and constants for the rigid bone skinning engine
// Widths of the iterative square root and divide units, and the sequencer
// states of the top level.
// ============================================================================
package rbs_pkg;

    // square root unit: 64-bit radicand, 32-bit root
    localparam int RAD_W  = 64;
    localparam int ROOT_W = 32;

    // divide unit: magnitude of one vector component, quotient width
    localparam int MAG_W  = 19;
    localparam int QUO_W  = 16;
    localparam int DVD_W  = 47;
    localparam int UNIT_SHIFT = 27;

    // signed width of a vector component under normalization
    localparam int COMP_W = 19;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_QSQ,
        ST_SQRT,
        ST_DIV,
        ST_DIV_WAIT,
        ST_QPROD,
        ST_ROTW,
        ST_LOAD,
        ST_POS,
        ST_NRM,
        ST_NSQ,
        ST_OUT
    } state_t;

endpackage

FILE: sv/rbs_ram.sv
// ============================================================================
// rbs_ram: generic single-port-write, single-port-read memory
// One write and one read address per cycle, read data registered.
// ============================================================================
module rbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 576
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/rbs_isqrt.sv
// ============================================================================
// rbs_isqrt: iterative integer square root
// Digit-by-digit floor square root, one root bit per cycle.
// ============================================================================
module rbs_isqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [rbs_pkg::RAD_W-1:0]    rad,
    output logic                         done,
    output logic [rbs_pkg::ROOT_W-1:0]   root
);

    import rbs_pkg::*;

    localparam int STEP_W = $clog2(ROOT_W);
    localparam int REM_W  = ROOT_W + 3;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    // one trial subtraction per cycle
    always_comb
    begin
        rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1:RAD_W-2]};
        trial  = {1'b0, root_reg, 2'b01};
        ge     = (rem_sh >= trial);
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(ROOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: sv/rbs_div.sv
// ============================================================================
// rbs_div: iterative restoring divider for vector normalization
// Computes (mag * 2^27 + root / 2) / root, one quotient bit per cycle.
// ============================================================================
module rbs_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rbs_pkg::MAG_W-1:0]   mag,
    input  logic [rbs_pkg::ROOT_W-1:0]  root,
    output logic                        done,
    output logic [rbs_pkg::QUO_W-1:0]   quot
);

    import rbs_pkg::*;

    localparam int STEP_W = $clog2(QUO_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [ROOT_W-1:0] den_reg;
    logic [ROOT_W-1:0] rem_reg;
    logic [QUO_W-1:0]  low_reg;

    logic [DVD_W-1:0]  dvd;
    logic [ROOT_W:0]   trial;
    logic              ge;

    // rounded dividend and one trial subtraction per cycle
    always_comb
    begin
        dvd   = {1'b0, mag, {UNIT_SHIFT{1'b0}}} + DVD_W'(root >> 1);
        trial = {rem_reg, low_reg[QUO_W-1]};
        ge    = (trial >= {1'b0, den_reg});
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(QUO_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: quotient bits shift in where dividend bits shift out
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= root;
            rem_reg <= ROOT_W'(dvd[DVD_W-1:QUO_W]);
            low_reg <= dvd[QUO_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? ROOT_W'(trial - {1'b0, den_reg}) : trial[ROOT_W-1:0];
            low_reg <= {low_reg[QUO_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = low_reg;

endmodule

FILE: sv/rigid_bone_skinning_top.sv
// ============================================================================
// rigid_bone_skinning_top: rigid one-bone-per-vertex skinning engine
// Pose requests build a rotation from a quaternion and store it with the
// translation; vertex requests return the skinned position and normal.
// ============================================================================
// a pose with a zero quaternion and a vertex whose rotated normal is zero skip
//   the square root and the divides
// throughput: one request at a time; the 32-step square root and the 16-step
//   divide per vector component, both on shared units, set the figure
// reset: rst_n clears the sequencer and the output valid; the bone stores
//   are not cleared and hold garbage until a pose request writes them
module rigid_bone_skinning_top #(
    parameter int MAX_BONES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    input  logic [5:0]         bone_index,
    input  logic signed [31:0] vec_x,
    input  logic signed [31:0] vec_y,
    input  logic signed [31:0] vec_z,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic signed [15:0] normal_x,
    input  logic signed [15:0] normal_y,
    input  logic signed [15:0] normal_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] out_pos_x,
    output logic signed [31:0] out_pos_y,
    output logic signed [31:0] out_pos_z,
    output logic signed [15:0] out_nrm_x,
    output logic signed [15:0] out_nrm_y,
    output logic signed [15:0] out_nrm_z
);

    import rbs_pkg::*;

    localparam int ROT_DEPTH = MAX_BONES * 9;
    localparam int TR_DEPTH  = MAX_BONES * 3;
    localparam int ROT_AW    = (ROT_DEPTH > 1) ? $clog2(ROT_DEPTH) : 1;
    localparam int TR_AW     = (TR_DEPTH > 1) ? $clog2(TR_DEPTH) : 1;
    localparam int ROT_N     = 9;
    localparam int VEC_N     = 3;
    localparam int QUAT_N    = 4;
    localparam int ACC_W     = 53;
    localparam int PROD_W    = 52;
    localparam int E_W       = 35;
    localparam int RND_SH    = 14;

    // sequencer
    state_t      state_reg;
    state_t      state_next;
    logic [3:0]  cnt_reg;
    logic [3:0]  cnt_next;
    logic [1:0]  row_reg;
    logic [1:0]  row_next;
    logic        out_valid_reg;

    // latched request and working values
    logic                     mode_reg;
    logic [5:0]               idx_reg;
    logic                     ok_reg;
    logic signed [31:0]       v_reg [VEC_N];
    logic signed [15:0]       n_reg [VEC_N];
    logic signed [COMP_W-1:0] c_reg [QUAT_N];
    logic signed [15:0]       m_reg [ROT_N];
    logic signed [31:0]       t_reg [VEC_N];
    logic signed [31:0]       p_reg [ROT_N];
    logic signed [31:0]       pos_reg [VEC_N];
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    // output registers
    logic signed [31:0] opx_reg;
    logic signed [31:0] opy_reg;
    logic signed [31:0] opz_reg;
    logic signed [15:0] onx_reg;
    logic signed [15:0] ony_reg;
    logic signed [15:0] onz_reg;

    // control
    logic in_acc;
    logic ok_in;
    logic rot_we;
    logic tr_we;
    logic sqrt_start;
    logic div_start;
    logic out_load;
    logic last_comp;

    // datapath nets
    logic signed [32:0]       mul_a;
    logic signed [18:0]       mul_b;
    logic [3:0]               m_idx;
    logic signed [15:0]       m_sel;
    logic signed [31:0]       v_sel;
    logic signed [15:0]       n_sel;
    logic signed [ACC_W-1:0]  sum_c;
    logic signed [ACC_W-1:0]  rnd_sum;
    logic signed [31:0]       pos_sat;
    logic signed [ACC_W-1:0]  acc_init;
    logic signed [E_W-1:0]    pe [ROT_N];
    logic signed [E_W-1:0]    e_val;
    logic signed [E_W-1:0]    e_rnd;
    logic signed [15:0]       e_sat;
    logic signed [COMP_W-1:0] c_sel;
    logic [MAG_W-1:0]         c_mag;
    logic                     c_neg;
    logic [15:0]              base16;
    logic [15:0]              tbase16;
    logic [ROT_AW-1:0]        rot_addr;
    logic [TR_AW-1:0]         tr_addr;
    logic [15:0]              rot_rdata;
    logic [31:0]              tr_rdata;
    logic [15:0]              rot_wdata;
    logic [31:0]              tr_wdata;
    logic                     sqrt_done;
    logic [ROOT_W-1:0]        sqrt_root;
    logic                     div_done;
    logic [QUO_W-1:0]         div_quot;

    // request handshake
    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign ok_in    = ({3'b000, bone_index} < 9'(MAX_BONES));

    // store addresses: bone base plus element counter
    always_comb
    begin
        base16   = ({10'b0, idx_reg} << 3) + {10'b0, idx_reg};
        tbase16  = ({10'b0, idx_reg} << 1) + {10'b0, idx_reg};
        rot_addr = ROT_AW'(base16 + {12'b0, cnt_reg});
        tr_addr  = TR_AW'(tbase16 + {12'b0, cnt_reg});
    end

    // operand selection for the shared multiplier
    always_comb
    begin
        m_idx = 4'({row_reg, 1'b0} + {2'b00, row_reg}) + cnt_reg;
        m_sel = (m_idx < 4'(ROT_N)) ? m_reg[m_idx] : 16'sd0;
        case (cnt_reg)
            4'd0:    begin v_sel = v_reg[0]; n_sel = n_reg[0]; c_sel = c_reg[0]; end
            4'd1:    begin v_sel = v_reg[1]; n_sel = n_reg[1]; c_sel = c_reg[1]; end
            4'd2:    begin v_sel = v_reg[2]; n_sel = n_reg[2]; c_sel = c_reg[2]; end
            4'd3:    begin v_sel = '0;       n_sel = '0;       c_sel = c_reg[3]; end
            default: begin v_sel = '0;       n_sel = '0;       c_sel = '0;       end
        endcase
        c_neg = c_sel[COMP_W-1];
        c_mag = c_neg ? MAG_W'(-c_sel) : MAG_W'(c_sel);

        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_QSQ, ST_NSQ:
            begin
                mul_a = 33'(c_sel);
                mul_b = c_sel;
            end
            ST_QPROD:
            begin
                case (cnt_reg)
                    4'd0:    begin mul_a = 33'(c_reg[1]); mul_b = c_reg[1]; end
                    4'd1:    begin mul_a = 33'(c_reg[2]); mul_b = c_reg[2]; end
                    4'd2:    begin mul_a = 33'(c_reg[3]); mul_b = c_reg[3]; end
                    4'd3:    begin mul_a = 33'(c_reg[1]); mul_b = c_reg[2]; end
                    4'd4:    begin mul_a = 33'(c_reg[1]); mul_b = c_reg[3]; end
                    4'd5:    begin mul_a = 33'(c_reg[2]); mul_b = c_reg[3]; end
                    4'd6:    begin mul_a = 33'(c_reg[0]); mul_b = c_reg[1]; end
                    4'd7:    begin mul_a = 33'(c_reg[0]); mul_b = c_reg[2]; end
                    4'd8:    begin mul_a = 33'(c_reg[0]); mul_b = c_reg[3]; end
                    default: begin mul_a = '0;            mul_b = '0;       end
                endcase
            end
            ST_POS:
            begin
                mul_a = 33'(v_sel);
                mul_b = 19'(m_sel);
            end
            ST_NRM:
            begin
                mul_a = 33'(n_sel);
                mul_b = 19'(m_sel);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // accumulate, round and saturate
    always_comb
    begin
        sum_c    = acc_reg + ACC_W'(prod_reg);
        rnd_sum  = (sum_c + ACC_W'(8192)) >>> RND_SH;
        if (rnd_sum > ACC_W'(64'sh7FFFFFFF))
        begin
            pos_sat = 32'sh7FFFFFFF;
        end
        else if (rnd_sum < -ACC_W'(64'sh80000000))
        begin
            pos_sat = -32'sh80000000;
        end
        else
        begin
            pos_sat = rnd_sum[31:0];
        end
        // next position row starts from its translation, normal rows from zero
        acc_init = (state_next == ST_POS) ? {{7{t_reg[row_next][31]}}, t_reg[row_next], 14'b0}
                                          : '0;
    end

    // rotation entry from the quaternion products (xx yy zz xy xz yz wx wy wz)
    always_comb
    begin
        for (int i = 0; i < ROT_N; i++)
        begin
            pe[i] = E_W'(p_reg[i]);
        end
        case (cnt_reg)
            4'd0:    e_val = (E_W'(1) <<< 28) - ((pe[1] + pe[2]) <<< 1);
            4'd1:    e_val = (pe[3] - pe[8]) <<< 1;
            4'd2:    e_val = (pe[4] + pe[7]) <<< 1;
            4'd3:    e_val = (pe[3] + pe[8]) <<< 1;
            4'd4:    e_val = (E_W'(1) <<< 28) - ((pe[0] + pe[2]) <<< 1);
            4'd5:    e_val = (pe[5] - pe[6]) <<< 1;
            4'd6:    e_val = (pe[4] - pe[7]) <<< 1;
            4'd7:    e_val = (pe[5] + pe[6]) <<< 1;
            4'd8:    e_val = (E_W'(1) <<< 28) - ((pe[0] + pe[1]) <<< 1);
            default: e_val = '0;
        endcase
        e_rnd = (e_val + E_W'(8192)) >>> RND_SH;
        if (e_rnd > E_W'(32767))
        begin
            e_sat = 16'sh7FFF;
        end
        else if (e_rnd < -E_W'(32768))
        begin
            e_sat = -16'sh8000;
        end
        else
        begin
            e_sat = e_rnd[15:0];
        end
        rot_wdata = e_sat;
        tr_wdata  = v_sel;
    end

    // next state
    always_comb
    begin
        last_comp  = mode_reg ? (cnt_reg == 4'd2) : (cnt_reg == 4'd3);
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (mode)
                    begin
                        state_next = ST_LOAD;
                    end
                    else if (ok_in)
                    begin
                        state_next = ST_QSQ;
                    end
                end
            end
            ST_QSQ:
            begin
                if (cnt_reg == 4'd4)
                begin
                    state_next = (sum_c == '0) ? ST_QPROD : ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (sqrt_done)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (!last_comp)
                    begin
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = mode_reg ? ST_OUT : ST_QPROD;
                    end
                end
            end
            ST_QPROD:
            begin
                if (cnt_reg == 4'd9)
                begin
                    state_next = ST_ROTW;
                end
            end
            ST_ROTW:
            begin
                if (cnt_reg == 4'd8)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOAD:
            begin
                if (cnt_reg == 4'd9)
                begin
                    state_next = ST_POS;
                end
            end
            ST_POS:
            begin
                if (cnt_reg == 4'd3 && row_reg == 2'd2)
                begin
                    state_next = ST_NRM;
                end
            end
            ST_NRM:
            begin
                if (cnt_reg == 4'd3 && row_reg == 2'd2)
                begin
                    state_next = ST_NSQ;
                end
            end
            ST_NSQ:
            begin
                if (cnt_reg == 4'd3)
                begin
                    state_next = (sum_c == '0) ? ST_OUT : ST_SQRT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // step counter and row
    always_comb
    begin
        cnt_next = cnt_reg;
        row_next = row_reg;
        case (state_reg)
            ST_QSQ, ST_QPROD, ST_ROTW, ST_LOAD, ST_NSQ:
            begin
                cnt_next = (state_next != state_reg) ? 4'd0 : cnt_reg + 4'd1;
            end
            ST_POS, ST_NRM:
            begin
                if (cnt_reg == 4'd3)
                begin
                    cnt_next = 4'd0;
                    row_next = (row_reg == 2'd2) ? 2'd0 : row_reg + 2'd1;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    cnt_next = last_comp ? 4'd0 : cnt_reg + 4'd1;
                end
            end
            ST_SQRT, ST_DIV:
            begin
                cnt_next = cnt_reg;
            end
            default:
            begin
                cnt_next = 4'd0;
                row_next = 2'd0;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        rot_we     = 1'b0;
        tr_we      = 1'b0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_QSQ:      sqrt_start = (cnt_reg == 4'd4) && (sum_c != '0);
            ST_NSQ:      sqrt_start = (cnt_reg == 4'd3) && (sum_c != '0);
            ST_DIV:      div_start  = 1'b1;
            ST_ROTW:
            begin
                rot_we = 1'b1;
                tr_we  = (cnt_reg < 4'd3);
            end
            ST_OUT:      out_load   = !out_valid_reg || !out_stall;
            default:
            begin
                rot_we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            row_reg   <= row_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // shared multiplier, registered product
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // working registers
    always_ff @(posedge clk)
    begin
        // capture request
        if (in_acc)
        begin
            mode_reg <= mode;
            idx_reg  <= bone_index;
            ok_reg   <= ok_in;
            v_reg[0] <= vec_x;
            v_reg[1] <= vec_y;
            v_reg[2] <= vec_z;
            n_reg[0] <= normal_x;
            n_reg[1] <= normal_y;
            n_reg[2] <= normal_z;
            c_reg[0] <= COMP_W'(quat_w);
            c_reg[1] <= COMP_W'(quat_x);
            c_reg[2] <= COMP_W'(quat_y);
            c_reg[3] <= COMP_W'(quat_z);
        end

        // accumulator, first translation is in place by the last load step
        case (state_reg)
            ST_QSQ, ST_NSQ:
            begin
                acc_reg <= (cnt_reg == 4'd0) ? '0 : sum_c;
            end
            ST_POS, ST_NRM:
            begin
                if (cnt_reg == 4'd3)
                begin
                    acc_reg <= acc_init;
                end
                else if (cnt_reg != 4'd0)
                begin
                    acc_reg <= sum_c;
                end
            end
            ST_LOAD:
            begin
                acc_reg <= {{7{t_reg[0][31]}}, t_reg[0], 14'b0};
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase

        // bone entry load, zeros for an out-of-range bone
        if (state_reg == ST_LOAD && cnt_reg != 4'd0)
        begin
            m_reg[cnt_reg - 4'd1] <= ok_reg ? signed'(rot_rdata) : 16'sd0;
            if (cnt_reg < 4'd4)
            begin
                t_reg[2'(cnt_reg - 4'd1)] <= ok_reg ? signed'(tr_rdata) : 32'sd0;
            end
        end

        // quaternion products
        if (state_reg == ST_QPROD && cnt_reg != 4'd0)
        begin
            p_reg[cnt_reg - 4'd1] <= prod_reg[31:0];
        end

        // row results
        if (state_reg == ST_POS && cnt_reg == 4'd3)
        begin
            pos_reg[row_reg] <= pos_sat;
        end
        if (state_reg == ST_NRM && cnt_reg == 4'd3)
        begin
            c_reg[row_reg] <= rnd_sum[COMP_W-1:0];
        end

        // normalized component
        if (state_reg == ST_DIV_WAIT && div_done)
        begin
            c_reg[cnt_reg[1:0]] <= c_neg ? -COMP_W'(div_quot) : COMP_W'(div_quot);
        end
    end

    // output registers
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            opx_reg <= pos_reg[0];
            opy_reg <= pos_reg[1];
            opz_reg <= pos_reg[2];
            onx_reg <= (c_reg[0] > 19'sd32767) ? 16'sh7FFF :
                       (c_reg[0] < -19'sd32768) ? -16'sh8000 : c_reg[0][15:0];
            ony_reg <= (c_reg[1] > 19'sd32767) ? 16'sh7FFF :
                       (c_reg[1] < -19'sd32768) ? -16'sh8000 : c_reg[1][15:0];
            onz_reg <= (c_reg[2] > 19'sd32767) ? 16'sh7FFF :
                       (c_reg[2] < -19'sd32768) ? -16'sh8000 : c_reg[2][15:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pos_x = opx_reg;
    assign out_pos_y = opy_reg;
    assign out_pos_z = opz_reg;
    assign out_nrm_x = onx_reg;
    assign out_nrm_y = ony_reg;
    assign out_nrm_z = onz_reg;

    // bone rotation store
    rbs_ram #(
        .WIDTH (16),
        .DEPTH (ROT_DEPTH)
    ) u_rot_ram (
        .clk   (clk),
        .we    (rot_we),
        .waddr (rot_addr),
        .wdata (rot_wdata),
        .raddr (rot_addr),
        .rdata (rot_rdata)
    );

    // bone translation store
    rbs_ram #(
        .WIDTH (32),
        .DEPTH (TR_DEPTH)
    ) u_tr_ram (
        .clk   (clk),
        .we    (tr_we),
        .waddr (tr_addr),
        .wdata (tr_wdata),
        .raddr (tr_addr),
        .rdata (tr_rdata)
    );

    // shared square root
    rbs_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .rad   ({sum_c[37:0], 26'b0}),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    // shared divider
    rbs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .mag   (c_mag),
        .root  (sqrt_root),
        .done  (div_done),
        .quot  (div_quot)
    );

    // checks
    a_sqrt_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_done |-> state_reg == ST_SQRT)
        else $error("square root finished outside its wait state");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV_WAIT)
        else $error("divide finished outside its wait state");

    a_rot_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rot_we |-> ok_reg && !mode_reg)
        else $error("bone store written for an invalid pose request");

    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output state");

endmodule
